// File: src/itrt_pkg.sv
// Shared types and constants for the integer to radix text converter.
// Used by the converter top level and by its port checker.
// No dependencies.
package itrt_pkg;

    // Widest radix the alphabet may hold, and the width of the input value.
    localparam int MAX_RADIX  = 16;
    localparam int VALUE_BITS = 32;

    // Division unit: quotient bits resolved per cycle and cycles per digit.
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = VALUE_BITS / DIV_STEPS;
    localparam int STEP_W     = $clog2(DIV_CYCLES);

    // Digit buffer: one entry per possible digit (radix two gives the most).
    localparam int DIGIT_DEPTH = VALUE_BITS;
    localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH);
    localparam int DIGIT_CNT_W = $clog2(DIGIT_DEPTH + 1);
    localparam int ALPHA_IDX_W = $clog2(MAX_RADIX);

    // Field widths.
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 5;
    localparam int WORD_W  = 64;
    localparam int INDEX_W = 2;

    // Configuration register indexes.
    typedef enum logic [INDEX_W-1:0] {
        REG_BASE_LEN    = 2'd0,
        REG_DIGITS_LOW  = 2'd1,
        REG_DIGITS_HIGH = 2'd2
    } cfg_index_t;

    // Reset values of the configuration registers: decimal alphabet.
    localparam logic [LEN_W-1:0]  BASE_LEN_RST    = 5'd10;
    localparam logic [WORD_W-1:0] DIGITS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [WORD_W-1:0] DIGITS_HIGH_RST = 64'h0000_0000_0000_3938;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    // Smallest usable radix.
    localparam logic [LEN_W-1:0] MIN_RADIX = 5'd2;

endpackage

// File: src/integer_to_radix_text.sv
// Integer to radix text converter: top level with sequencer and shared divider.
// Depends on itrt_pkg.
//
// Converts a signed 32-bit value to text in the radix set by base_len, using the
// configured alphabet, and delivers one character per output transfer, most
// significant first, with a leading '-' for negative values and last_char on the
// final character. A zero value gives '0'; an invalid alphabet gives one result
// with bad_base set. One value is handled at a time and value_ready is low until
// its last character has been loaded into the output register. Each value passes
// an alphabet check, one character against every later one per cycle, then, for a
// valid nonzero value, the shared compare-subtract divider, which resolves 4
// quotient bits a cycle and stores one digit at a time, then the output, one
// character per cycle while the output is not stalled.
module integer_to_radix_text
    import itrt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Configuration writes
    input  logic                     cfg_write,
    input  logic [INDEX_W-1:0]       cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,
    // Input value channel
    input  logic                     value_valid,
    output logic                     value_ready,
    input  logic signed [VALUE_BITS-1:0] value,
    // Output text channel
    output logic                     text_valid,
    input  logic                     text_ready,
    output logic [CHAR_W-1:0]        text_char,
    output logic                     last_char,
    output logic                     bad_base
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SIGN,
        S_DIGITS,
        S_ONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         base_len_reg, base_len_next;
    logic [WORD_W-1:0]        digits_low_reg, digits_low_next;
    logic [WORD_W-1:0]        digits_high_reg, digits_high_next;
    logic                     neg_reg, neg_next;
    logic                     zero_reg, zero_next;
    logic                     err_reg, err_next;
    logic [VALUE_BITS-1:0]    mag_reg, mag_next;
    logic [ALPHA_IDX_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [ALPHA_IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [DIGIT_CNT_W-1:0]   nd_reg, nd_next;
    logic                     text_valid_reg, text_valid_next;
    logic [CHAR_W-1:0]        text_char_reg, text_char_next;
    logic                     last_char_reg, last_char_next;
    logic                     bad_base_reg, bad_base_next;

    // Digit buffer, filled least significant digit first.
    logic [ALPHA_IDX_W-1:0]   digit_mem [DIGIT_DEPTH];
    logic                     digit_we;
    logic [DIGIT_IDX_W-1:0]   digit_waddr;
    logic [ALPHA_IDX_W-1:0]   digit_wdata;
    logic [DIGIT_IDX_W-1:0]   digit_raddr;
    logic [ALPHA_IDX_W-1:0]   digit_rd_reg;

    logic [2*WORD_W-1:0]      alphabet;
    logic                     out_free;
    logic [VALUE_BITS-1:0]    value_u;
    logic [CHAR_W-1:0]        chk_char;
    logic                     chk_bad;
    logic [ALPHA_IDX_W-1:0]   div_rem;
    logic [VALUE_BITS-1:0]    div_quot;
    logic [ALPHA_IDX_W-1:0]   last_idx;

    assign alphabet    = {digits_high_reg, digits_low_reg};
    assign out_free    = !text_valid_reg || text_ready;
    assign value_u     = VALUE_BITS'(value);
    assign last_idx    = ALPHA_IDX_W'(base_len_reg - 5'd1);
    // The buffer read is registered, so it follows the digit count of the next cycle.
    assign digit_raddr = DIGIT_IDX_W'(nd_next - DIGIT_CNT_W'(1));

    assign value_ready = (state_reg == S_IDLE);
    assign text_valid  = text_valid_reg;
    assign text_char   = text_char_reg;
    assign last_char   = last_char_reg;
    assign bad_base    = bad_base_reg;

    // Alphabet check: the current character against the forbidden codes
    // and against every later character inside the radix.
    always_comb
    begin
        chk_char = alphabet[CHAR_W*chk_idx_reg +: CHAR_W];
        chk_bad  = (chk_char == CHAR_NUL) || (chk_char == CHAR_PLUS)
                   || (chk_char == CHAR_MINUS);
        for (int j = 0; j < MAX_RADIX; j++)
        begin
            if ((LEN_W'(j) > LEN_W'(chk_idx_reg)) && (LEN_W'(j) < base_len_reg)
                && (alphabet[CHAR_W*j +: CHAR_W] == chk_char))
            begin
                chk_bad = 1'b1;
            end
        end
    end

    // Shared divider: restoring compare-subtract, several quotient bits a cycle.
    always_comb
    begin
        logic [LEN_W-1:0] trial;
        trial    = '0;
        div_rem  = rem_reg;
        div_quot = mag_reg;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial    = {div_rem, div_quot[VALUE_BITS-1]};
            div_quot = {div_quot[VALUE_BITS-2:0], 1'b0};
            if (trial >= base_len_reg)
            begin
                div_rem     = ALPHA_IDX_W'(trial - base_len_reg);
                div_quot[0] = 1'b1;
            end
            else
            begin
                div_rem = trial[ALPHA_IDX_W-1:0];
            end
        end
    end

    // Sequencer and output register next state.
    always_comb
    begin
        state_next       = state_reg;
        base_len_next    = base_len_reg;
        digits_low_next  = digits_low_reg;
        digits_high_next = digits_high_reg;
        neg_next         = neg_reg;
        zero_next        = zero_reg;
        err_next         = err_reg;
        mag_next         = mag_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        chk_idx_next     = chk_idx_reg;
        nd_next          = nd_reg;
        text_valid_next  = text_valid_reg && !text_ready;
        text_char_next   = text_char_reg;
        last_char_next   = last_char_reg;
        bad_base_next    = bad_base_reg;
        digit_we         = 1'b0;
        digit_waddr      = nd_reg[DIGIT_IDX_W-1:0];
        digit_wdata      = div_rem;

        // Configuration writes; indexes outside the list are ignored.
        if (cfg_write)
        begin
            case (cfg_index)
                REG_BASE_LEN:    base_len_next    = cfg_data[LEN_W-1:0];
                REG_DIGITS_LOW:  digits_low_next  = cfg_data;
                REG_DIGITS_HIGH: digits_high_next = cfg_data;
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (value_valid)
                begin
                    neg_next     = value_u[VALUE_BITS-1];
                    mag_next     = value_u[VALUE_BITS-1] ? (VALUE_BITS'(0) - value_u)
                                                         : value_u;
                    zero_next    = (value_u == '0);
                    err_next     = 1'b0;
                    rem_next     = '0;
                    step_next    = '0;
                    chk_idx_next = '0;
                    nd_next      = '0;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((base_len_reg < MIN_RADIX) || (base_len_reg > LEN_W'(MAX_RADIX))
                    || chk_bad)
                begin
                    err_next   = 1'b1;
                    state_next = S_ONE;
                end
                else if (chk_idx_reg == last_idx)
                begin
                    state_next = zero_reg ? S_ONE : S_DIV;
                end
                else
                begin
                    chk_idx_next = chk_idx_reg + ALPHA_IDX_W'(1);
                end
            end
            S_DIV:
            begin
                mag_next  = div_quot;
                rem_next  = div_rem;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_CYCLES - 1))
                begin
                    // Digit complete: store the remainder, go on with the quotient.
                    digit_we = 1'b1;
                    nd_next  = nd_reg + DIGIT_CNT_W'(1);
                    rem_next = '0;
                    if (div_quot == '0)
                    begin
                        state_next = neg_reg ? S_SIGN : S_DIGITS;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    text_valid_next = 1'b1;
                    text_char_next  = CHAR_MINUS;
                    last_char_next  = 1'b0;
                    bad_base_next   = 1'b0;
                    state_next      = S_DIGITS;
                end
            end
            S_DIGITS:
            begin
                if (out_free)
                begin
                    text_valid_next = 1'b1;
                    text_char_next  = alphabet[CHAR_W*digit_rd_reg +: CHAR_W];
                    last_char_next  = (nd_reg == DIGIT_CNT_W'(1));
                    bad_base_next   = 1'b0;
                    nd_next         = nd_reg - DIGIT_CNT_W'(1);
                    if (nd_reg == DIGIT_CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ONE:
            begin
                // Single result: either the error result or the zero text.
                if (out_free)
                begin
                    text_valid_next = 1'b1;
                    text_char_next  = err_reg ? CHAR_NUL : CHAR_ZERO;
                    last_char_next  = 1'b1;
                    bad_base_next   = err_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, configuration and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            base_len_reg    <= BASE_LEN_RST;
            digits_low_reg  <= DIGITS_LOW_RST;
            digits_high_reg <= DIGITS_HIGH_RST;
            neg_reg         <= 1'b0;
            zero_reg        <= 1'b0;
            err_reg         <= 1'b0;
            step_reg        <= '0;
            chk_idx_reg     <= '0;
            nd_reg          <= '0;
            text_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            base_len_reg    <= base_len_next;
            digits_low_reg  <= digits_low_next;
            digits_high_reg <= digits_high_next;
            neg_reg         <= neg_next;
            zero_reg        <= zero_next;
            err_reg         <= err_next;
            step_reg        <= step_next;
            chk_idx_reg     <= chk_idx_next;
            nd_reg          <= nd_next;
            text_valid_reg  <= text_valid_next;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        rem_reg       <= rem_next;
        text_char_reg <= text_char_next;
        last_char_reg <= last_char_next;
        bad_base_reg  <= bad_base_next;
    end

    // Digit buffer: write port, and a registered read of the top stored digit.
    // A digit written in this cycle is the one read next, so it is passed through.
    always_ff @(posedge clk)
    begin
        if (digit_we)
        begin
            digit_mem[digit_waddr] <= digit_wdata;
            digit_rd_reg           <= digit_wdata;
        end
        else
        begin
            digit_rd_reg <= digit_mem[digit_raddr];
        end
    end

endmodule

// File: src/itrt_checker.sv
// Port checker for the integer to radix text converter, with its bind.
// Depends on itrt_pkg; attaches to integer_to_radix_text.
module itrt_checker
    import itrt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     value_valid,
    input  logic                     value_ready,
    input  logic                     text_valid,
    input  logic                     text_ready,
    input  logic [CHAR_W-1:0]        text_char,
    input  logic                     last_char,
    input  logic                     bad_base
);

    // A stalled output transfer keeps its character and flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid && $stable(text_char)
            && $stable(last_char) && $stable(bad_base))
        else $error("output changed while stalled");

    // The error result is a single, final, empty character.
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && bad_base |-> last_char && (text_char == CHAR_NUL))
        else $error("error result malformed");

    // Text characters are never the null byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !bad_base |-> (text_char != CHAR_NUL))
        else $error("null character in text");

    // Once a value is taken, the converter is busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && value_ready |=> !value_ready)
        else $error("input taken twice in a row");

endmodule

bind integer_to_radix_text itrt_checker u_itrt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .text_valid  (text_valid),
    .text_ready  (text_ready),
    .text_char   (text_char),
    .last_char   (last_char),
    .bad_base    (bad_base)
);

// File: test/integer_to_radix_text_checker.sv
`timescale 1ns / 100ps
// Port checker for the integer to radix text converter: it follows the register writes,
// predicts the characters of every accepted value and compares each output transfer.
// Depends on itrt_pkg.
module integer_to_radix_text_checker
    import itrt_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [INDEX_W-1:0]           cfg_index,
    input  logic [WORD_W-1:0]            cfg_data,
    input  logic                         value_valid,
    input  logic                         value_ready,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         text_valid,
    input  logic                         text_ready,
    input  logic [CHAR_W-1:0]            text_char,
    input  logic                         last_char,
    input  logic                         bad_base,
    output int                           pending_chars,
    output int                           mismatches
);

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              bad;
    } char_item_t;

    // Shadow copy of the alphabet registers.
    logic [LEN_W-1:0]  base_len_sh;
    logic [WORD_W-1:0] digits_low_sh;
    logic [WORD_W-1:0] digits_high_sh;

    char_item_t expected_chars[$];
    char_item_t want;
    int         fail_count = 0;

    assign mismatches = fail_count;

    task automatic report_mismatch(input string what);
        $display("%0t: text mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // Character i of the configured alphabet.
    function automatic logic [CHAR_W-1:0] alpha_at(input int i);
        if (i < 8)
            return digits_low_sh[8*i +: 8];
        return digits_high_sh[8*(i-8) +: 8];
    endfunction

    // The alphabet is usable when its size is a legal radix and every character in use
    // is distinct and is neither a sign nor NUL.
    function automatic logic alphabet_valid();
        logic [CHAR_W-1:0] c;
        if (base_len_sh < MIN_RADIX || int'(base_len_sh) > MAX_RADIX)
            return 1'b0;
        for (int i = 0; i < int'(base_len_sh); i++)
        begin
            c = alpha_at(i);
            if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS)
                return 1'b0;
            for (int j = i + 1; j < int'(base_len_sh); j++)
                if (alpha_at(j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void push_char(input logic [CHAR_W-1:0] code, input logic last,
                                      input logic bad);
        char_item_t item;
        item.code = code;
        item.last = last;
        item.bad  = bad;
        expected_chars.push_back(item);
    endfunction

    // Expected text of one value: sign first, then digits most significant first.
    function automatic void predict_text(input logic [VALUE_BITS-1:0] raw);
        logic [CHAR_W-1:0]     rev [VALUE_BITS];
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] radix;
        logic                  neg;
        int                    nd;
        neg = raw[VALUE_BITS-1];
        mag = neg ? -raw : raw;
        nd  = 0;
        if (!alphabet_valid())
        begin
            push_char(CHAR_NUL, 1'b1, 1'b1);
            return;
        end
        if (mag == '0)
        begin
            push_char(CHAR_ZERO, 1'b1, 1'b0);
            return;
        end
        radix = VALUE_BITS'(base_len_sh);
        while (mag != '0)
        begin
            rev[nd] = alpha_at(int'(mag % radix));
            mag     = mag / radix;
            nd++;
        end
        if (neg)
            push_char(CHAR_MINUS, 1'b0, 1'b0);
        for (int k = nd - 1; k >= 0; k--)
            push_char(rev[k], k == 0, 1'b0);
    endfunction

    // Follow register writes, predict on each input transfer, check each output transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_sh    = BASE_LEN_RST;
            digits_low_sh  = DIGITS_LOW_RST;
            digits_high_sh = DIGITS_HIGH_RST;
            expected_chars.delete();
            pending_chars <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BASE_LEN:    base_len_sh    = cfg_data[LEN_W-1:0];
                    REG_DIGITS_LOW:  digits_low_sh  = cfg_data;
                    REG_DIGITS_HIGH: digits_high_sh = cfg_data;
                    default: ;
                endcase
            end

            if (value_valid && value_ready)
                predict_text(value);

            if (text_valid && text_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transfer char=0x%02h last=%b bad=%b",
                                              text_char, last_char, bad_base));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (text_char !== want.code)
                        report_mismatch($sformatf("text_char 0x%02h, expected 0x%02h",
                                                  text_char, want.code));
                    if (last_char !== want.last)
                        report_mismatch($sformatf("last_char %b, expected %b",
                                                  last_char, want.last));
                    if (bad_base !== want.bad)
                        report_mismatch($sformatf("bad_base %b, expected %b",
                                                  bad_base, want.bad));
                end
            end

            pending_chars <= expected_chars.size();
        end
    end

endmodule

// File: test/integer_to_radix_text_tb.sv
`timescale 1ns / 100ps
// Testbench top for the integer to radix text converter: clock, reset, register writes,
// value stimulus, output back-pressure and the verdict.
// Depends on itrt_pkg, integer_to_radix_text and integer_to_radix_text_checker.
module integer_to_radix_text_tb;
    import itrt_pkg::*;

    localparam logic [INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [WORD_W-1:0]  HEX_HIGH  = 64'h4645_4443_4241_3938;
    localparam logic [WORD_W-1:0]  BIN_LOW   = 64'hA5C3_7E01_FF00_3130;

    localparam int IDLE_HEAVY    = 83;
    localparam int IDLE_BOTH     = 26;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 9;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 5000;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_write;
    logic [INDEX_W-1:0]           cfg_index;
    logic [WORD_W-1:0]            cfg_data;
    logic                         value_valid;
    logic                         value_ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         text_valid;
    logic                         text_ready;
    logic [CHAR_W-1:0]            text_char;
    logic                         last_char;
    logic                         bad_base;

    int pending_chars;
    int mismatches;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int quiet_cycles;

    integer_to_radix_text i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value       (value),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_char   (text_char),
        .last_char   (last_char),
        .bad_base    (bad_base)
    );

    integer_to_radix_text_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .value_valid   (value_valid),
        .value_ready   (value_ready),
        .value         (value),
        .text_valid    (text_valid),
        .text_ready    (text_ready),
        .text_char     (text_char),
        .last_char     (last_char),
        .bad_base      (bad_base),
        .pending_chars (pending_chars),
        .mismatches    (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // One register write per cycle; the caller lowers cfg_write after the last one.
    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic load_alphabet(input logic [WORD_W-1:0] len_word,
                                 input logic [WORD_W-1:0] low_word,
                                 input logic [WORD_W-1:0] high_word);
        write_reg(REG_BASE_LEN, len_word);
        write_reg(REG_DIGITS_LOW, low_word);
        write_reg(REG_DIGITS_HIGH, high_word);
        cfg_write <= 1'b0;
    endtask

    // Offer one value after a random gap and hold it until the transfer happens.
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            value_valid <= 1'b0;
            @(negedge clk);
        end
        value       <= v;
        value_valid <= 1'b1;
        do
            @(posedge clk);
        while (!value_ready);
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted character has been transferred.
    task automatic drain();
        value_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_chars != 0);
    endtask

    // Mix of full-range values, small magnitudes, varied digit counts and extremes.
    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] v;
        int                    kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0: v = $urandom_range(0, 40);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = '0;
                endcase
            end
            2, 3, 4: v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
            default: v = $urandom;
        endcase
        if (kind != 1 && kind < 5 && $urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // Output back-pressure, with an occasional long hold-off on request.
    initial
    begin
        text_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                text_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            text_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when no transfer or write happens for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_write || (value_valid && value_ready) ||
                (text_valid && text_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [VALUE_BITS-1:0] picks [$];
        logic [CHAR_W-1:0]     chars [MAX_RADIX];
        bit                    used [256];
        logic [WORD_W-1:0]     len_word;
        logic [WORD_W-1:0]     low_word;
        logic [WORD_W-1:0]     high_word;
        int                    n;
        int                    pos;

        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = REG_BASE_LEN;
        cfg_data    = '0;
        value_valid = 1'b0;
        value       = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Decimal alphabet from reset: zero, small values, digit rollover and both extremes.
        picks = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'd1234567890};
        foreach (picks[i])
            send_value(picks[i]);
        drain();

        // A write to the unused index must leave the alphabet alone; then full hex.
        write_reg(REG_SPARE, '1);
        load_alphabet(64'd16, DIGITS_LOW_RST, HEX_HIGH);
        picks = '{32'd15, 32'd16, 32'hDEAD_BEEF, 32'h7FFF_FFFF, 32'h8000_0000};
        foreach (picks[i])
            send_value(picks[i]);
        drain();

        // Radix two: the most negative value gives the longest text.
        load_alphabet(64'd2, BIN_LOW, '1);
        picks = '{32'h8000_0000, 32'hFFFF_FFFF, 32'd5};
        foreach (picks[i])
            send_value(picks[i]);
        drain();

        // Invalid alphabets, one value each: radix too small, too large, with upper
        // data bits set, duplicate, plus sign, minus sign as the last character, NUL.
        load_alphabet(64'd0, DIGITS_LOW_RST, DIGITS_HIGH_RST);
        send_value(32'd0);
        drain();
        load_alphabet(64'd1, DIGITS_LOW_RST, DIGITS_HIGH_RST);
        send_value(32'd7);
        drain();
        load_alphabet(64'd17, DIGITS_LOW_RST, HEX_HIGH);
        send_value(32'd7);
        drain();
        load_alphabet('1, DIGITS_LOW_RST, HEX_HIGH);
        send_value(32'hFFFF_FFFB);
        drain();
        load_alphabet(64'd5, 64'h31_3332_3130, DIGITS_HIGH_RST);
        send_value(32'd0);
        drain();
        load_alphabet(64'd4, 64'h3332_2B30, DIGITS_HIGH_RST);
        send_value(32'd3);
        drain();
        load_alphabet(64'd3, 64'h2D_3130, DIGITS_HIGH_RST);
        send_value(32'hFFFF_FFFF);
        drain();
        load_alphabet(64'd10, DIGITS_LOW_RST, 64'h0038);
        send_value(32'd42);
        drain();

        // Long output hold-off while values keep coming, so the converter backs up.
        load_alphabet(64'(BASE_LEN_RST), DIGITS_LOW_RST, DIGITS_HIGH_RST);
        hold_request = 1'b1;
        repeat (4)
            send_value(random_value());
        drain();

        // Random phases: a fresh alphabet each, mostly well formed, with rotating idling.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            n = $urandom_range(MIN_RADIX, MAX_RADIX);
            foreach (used[u])
                used[u] = 1'b0;
            for (int i = 0; i < MAX_RADIX; i++)
            begin
                if (i < n)
                begin
                    do
                        chars[i] = CHAR_W'($urandom_range(1, 255));
                    while (chars[i] == CHAR_PLUS || chars[i] == CHAR_MINUS || used[chars[i]]);
                    used[chars[i]] = 1'b1;
                end
                else
                begin
                    chars[i] = CHAR_W'($urandom_range(0, 255));
                end
            end
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: n = $urandom_range(0, 1) ? $urandom_range(17, 31) : $urandom_range(0, 1);
                    1:
                    begin
                        pos = $urandom_range(1, n - 1);
                        chars[pos] = chars[$urandom_range(0, pos - 1)];
                    end
                    2: chars[$urandom_range(0, n - 1)] = CHAR_PLUS;
                    3: chars[$urandom_range(0, n - 1)] = CHAR_MINUS;
                    default: chars[$urandom_range(0, n - 1)] = CHAR_NUL;
                endcase
            end
            for (int i = 0; i < 8; i++)
            begin
                low_word[8*i +: 8]  = chars[i];
                high_word[8*i +: 8] = chars[i + 8];
            end
            len_word = {$urandom, $urandom};
            len_word[LEN_W-1:0] = LEN_W'(n);
            load_alphabet(len_word, low_word, high_word);

            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = IDLE_HEAVY;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = IDLE_HEAVY;
                end
                default:
                begin
                    send_idle_pct  = IDLE_BOTH;
                    recv_stall_pct = IDLE_BOTH;
                end
            endcase

            repeat (PHASE_ITEMS)
                send_value(random_value());
            drain();
        end

        // Let any stray output show up before the verdict.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
